// ===== sv/tot_to_charge_calibration_macros.svh =====
// Assertion macros for the ToT to charge calibration block.
`ifndef TOT_TO_CHARGE_CALIBRATION_MACROS_SVH
`define TOT_TO_CHARGE_CALIBRATION_MACROS_SVH
`ifndef SYNTH
`define TCC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TCC_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define TCC_ASSERT(lbl, prop, msg)
`define TCC_NEVER(lbl, expr, msg)
`endif
`endif

// ===== sv/tcc_pkg.sv =====
// Shared types and constants of the ToT to charge calibration block.
package tcc_pkg;
   localparam int ROWS_DEF = 256;
   localparam int COLS_DEF = 256;
   localparam int RAD_W    = 100;
   localparam int ROOT_W   = 50;
   localparam int REM_W    = 53;
   localparam int MAG_W    = 49;
   localparam int DEN_W    = 51;
   localparam int Q_W      = 32;
   localparam logic [18:0] TWO_K = 19'd492132;

   typedef enum logic [1:0] {
      METHOD_PASS  = 2'd0,
      METHOD_AVG   = 2'd1,
      METHOD_PIXEL = 2'd2,
      METHOD_RSVD  = 2'd3
   } method_type;

   typedef enum logic [2:0] {
      CSR_METHOD    = 3'd0,
      CSR_GAIN      = 3'd1,
      CSR_OFFSET    = 3'd2,
      CSR_CURVE     = 3'd3,
      CSR_THRESHOLD = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PASS  = 2'd0,
      KIND_ZERO  = 2'd1,
      KIND_SAT   = 2'd2,
      KIND_SOLVE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [13:0]       tot;
      logic [MAG_W-1:0]  mag;
      logic              neg;
      logic [DEN_W-1:0]  den;
   } sq_carry_type;

   typedef struct packed {
      kind_type          kind;
      logic [13:0]       tot;
   } div_carry_type;
endpackage

// ===== sv/tcc_req_if.sv =====
// Request channel interface: hits and pixel parameter loads.
interface tcc_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  row;
   logic [7:0]  col;
   logic [13:0] tot;
   logic [31:0] load_gain;
   logic [31:0] load_offset;
   logic [31:0] load_curve;
   logic [31:0] load_threshold;
   modport source (output valid, func, row, col, tot, load_gain, load_offset, load_curve,
                   load_threshold, input ready);
   modport sink (input valid, func, row, col, tot, load_gain, load_offset, load_curve,
                 load_threshold, output ready);
endinterface

// ===== sv/tcc_rsp_if.sv =====
// Result channel interface: calibrated charge.
interface tcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] charge_out;
   logic        root_ok;
   modport source (output valid, charge_out, root_ok, input ready);
   modport sink (input valid, charge_out, root_ok, output ready);
endinterface

// ===== sv/tcc_sqrt.sv =====
// Pipelined floor square root, two radicand bits per stage.
module tcc_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [tcc_pkg::RAD_W-1:0]         in_rad,
   input  tcc_pkg::sq_carry_type             in_carry,
   output logic                              out_valid,
   output logic [tcc_pkg::ROOT_W-1:0]        out_root,
   output tcc_pkg::sq_carry_type             out_carry
);
   localparam int N = tcc_pkg::ROOT_W;

   logic                        vld_ff   [N+1];
   logic [tcc_pkg::RAD_W-1:0]   rad_ff   [N+1];
   logic [tcc_pkg::REM_W-1:0]   rem_ff   [N+1];
   logic [N-1:0]                root_ff  [N+1];
   tcc_pkg::sq_carry_type       carry_ff [N+1];

   assign vld_ff[0]   = in_valid;
   assign rad_ff[0]   = in_rad;
   assign rem_ff[0]   = '0;
   assign root_ff[0]  = '0;
   assign carry_ff[0] = in_carry;

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [tcc_pkg::REM_W-1:0] rem_sh;
      logic [tcc_pkg::REM_W-1:0] trial;
      logic                      take;
      assign rem_sh = {rem_ff[i][tcc_pkg::REM_W-3:0], rad_ff[i][tcc_pkg::RAD_W-1 -: 2]};
      assign trial  = {1'b0, root_ff[i], 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[i+1]   <= {rad_ff[i][tcc_pkg::RAD_W-3:0], 2'b00};
            rem_ff[i+1]   <= take ? rem_sh - trial : rem_sh;
            root_ff[i+1]  <= {root_ff[i][N-2:0], take};
            carry_ff[i+1] <= carry_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_root  = root_ff[N];
   assign out_carry = carry_ff[N];
endmodule

// ===== sv/tcc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tcc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [tcc_pkg::DEN_W-1:0]     in_num,
   input  logic [tcc_pkg::DEN_W-1:0]     in_den,
   input  tcc_pkg::div_carry_type        in_carry,
   output logic                          out_valid,
   output logic [tcc_pkg::Q_W-1:0]       out_quot,
   output tcc_pkg::div_carry_type        out_carry
);
   localparam int N = tcc_pkg::Q_W;

   logic                        vld_ff   [N+1];
   logic [tcc_pkg::DEN_W-1:0]   rem_ff   [N+1];
   logic [tcc_pkg::DEN_W-1:0]   den_ff   [N+1];
   logic [N-1:0]                quot_ff  [N+1];
   tcc_pkg::div_carry_type      carry_ff [N+1];

   assign vld_ff[0]   = in_valid;
   assign rem_ff[0]   = in_num;
   assign den_ff[0]   = in_den;
   assign quot_ff[0]  = '0;
   assign carry_ff[0] = in_carry;

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [tcc_pkg::DEN_W:0] rem_sh;
      logic [tcc_pkg::DEN_W:0] diff;
      logic                    take;
      assign rem_sh = {rem_ff[i], 1'b0};
      assign diff   = rem_sh - {1'b0, den_ff[i]};
      assign take   = rem_sh >= {1'b0, den_ff[i]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1]   <= take ? diff[tcc_pkg::DEN_W-1:0] : rem_sh[tcc_pkg::DEN_W-1:0];
            den_ff[i+1]   <= den_ff[i];
            quot_ff[i+1]  <= {quot_ff[i][N-2:0], take};
            carry_ff[i+1] <= carry_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_quot  = quot_ff[N];
   assign out_carry = carry_ff[N];
endmodule

// ===== sv/tot_to_charge_calibration.sv =====
// ToT to charge calibration: a hit's ToT count is turned into deposited charge by
// inverting the curve ToT = a*Q + b - c/(Q - t), with parameters from the csr
// registers (method 1) or from per-pixel tables (method 2); method 0 passes ToT on.
// req_port carries hits (func 0) and table loads (func 1); a load writes the
// pixel's gain, offset, curve and threshold entries and gives no result.
// rsp_port returns charge_out (Q16.16, saturated) and root_ok for each hit.
// Throughput: one item per cycle while rsp_port does not stall. A result passes
// through stages 1 to 6, the 50-stage square root and the 32-stage divider in the pipeline.
// A table entry must be loaded before a hit on that pixel is converted in
// method 2; the tables are not cleared at reset.
// Reset empties the pipeline and restores the csr defaults.
// When rsp_port stalls, the whole pipeline holds and req_port.ready drops; no
// item is lost or repeated. Write csr registers only while the block is empty.
`include "tot_to_charge_calibration_macros.svh"
module tot_to_charge_calibration #(
   parameter int ROWS = tcc_pkg::ROWS_DEF,
   parameter int COLS = tcc_pkg::COLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcc_req_if.sink     req_port,
   tcc_rsp_if.source   rsp_port,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // csr registers
   tcc_pkg::method_type method_ff;
   logic [31:0] gain_ff, offset_ff, curve_ff, threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff    <= tcc_pkg::METHOD_PASS;
         gain_ff      <= 32'd12188;
         offset_ff    <= 32'd1872213;
         curve_ff     <= 32'd1174286;
         threshold_ff <= 32'd21372226;
      end else if (csr_we) begin
         unique case (csr_index)
            tcc_pkg::CSR_METHOD:    method_ff    <= tcc_pkg::method_type'(csr_wdata[1:0]);
            tcc_pkg::CSR_GAIN:      gain_ff      <= csr_wdata;
            tcc_pkg::CSR_OFFSET:    offset_ff    <= csr_wdata;
            tcc_pkg::CSR_CURVE:     curve_ff     <= csr_wdata;
            tcc_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // flow control: the whole pipeline moves when the output slot frees
   logic rsp_valid_ff;
   logic advance;
   logic accept;
   assign advance        = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;
   assign accept         = req_port.valid && advance;

   logic          in_range;
   logic [AW-1:0] idx;
   assign in_range = ({1'b0, req_port.row} < 9'(ROWS)) && ({1'b0, req_port.col} < 9'(COLS));
   assign idx      = AW'(32'(req_port.row) * 32'(COLS) + 32'(req_port.col));

   // parameter tables: gain, offset, curve, threshold packed in one word
   logic [127:0] table_mem [DEPTH];
   logic [127:0] rd_ff;

   always_ff @(posedge clock) begin
      if (accept && req_port.func && in_range) begin
         table_mem[idx] <= {req_port.load_gain, req_port.load_offset,
                            req_port.load_curve, req_port.load_threshold};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff <= table_mem[idx];
      end
   end

   // stage 1: captured hit
   logic s1_vld_ff, s1_inside_ff;
   logic [13:0] s1_tot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= accept && !req_port.func;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_inside_ff <= in_range;
         s1_tot_ff    <= req_port.tot;
      end
   end

   // stage 2: parameter selection
   tcc_pkg::kind_type s2_kind_in;
   logic [31:0] s2_a_in, s2_b_in, s2_c_in, s2_t_in;

   always_comb begin
      s2_a_in    = gain_ff;
      s2_b_in    = offset_ff;
      s2_c_in    = curve_ff;
      s2_t_in    = threshold_ff;
      s2_kind_in = tcc_pkg::KIND_PASS;
      unique case (method_ff)
         tcc_pkg::METHOD_AVG: s2_kind_in = tcc_pkg::KIND_SOLVE;
         tcc_pkg::METHOD_PIXEL: begin
            {s2_a_in, s2_b_in, s2_c_in, s2_t_in} = rd_ff;
            s2_kind_in = s1_inside_ff ? tcc_pkg::KIND_SOLVE : tcc_pkg::KIND_ZERO;
         end
         default: s2_kind_in = tcc_pkg::KIND_PASS;
      endcase
      if (s2_kind_in == tcc_pkg::KIND_SOLVE && s2_a_in == '0) begin
         s2_kind_in = tcc_pkg::KIND_ZERO;
      end
   end

   logic s2_vld_ff;
   tcc_pkg::kind_type s2_kind_ff;
   logic [13:0] s2_tot_ff;
   logic [31:0] s2_a_ff, s2_b_ff, s2_c_ff, s2_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_kind_ff <= s2_kind_in;
         s2_tot_ff  <= s1_tot_ff;
         s2_a_ff    <= s2_a_in;
         s2_b_ff    <= s2_b_in;
         s2_c_ff    <= s2_c_in;
         s2_t_ff    <= s2_t_in;
      end
   end

   // stage 3: products a*t, a*c, a*2k
   logic s3_vld_ff;
   tcc_pkg::kind_type s3_kind_ff;
   logic [13:0] s3_tot_ff;
   logic [31:0] s3_b_ff;
   logic [63:0] s3_at_ff, s3_ac_ff;
   logic [tcc_pkg::DEN_W-1:0] s3_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_kind_ff <= s2_kind_ff;
         s3_tot_ff  <= s2_tot_ff;
         s3_b_ff    <= s2_b_ff;
         s3_at_ff   <= 64'(s2_a_ff) * 64'(s2_t_ff);
         s3_ac_ff   <= 64'(s2_a_ff) * 64'(s2_c_ff);
         s3_den_ff  <= tcc_pkg::DEN_W'(s2_a_ff) * tcc_pkg::DEN_W'(tcc_pkg::TWO_K);
      end
   end

   // stage 4: u = a*t/2^16 + x - b, as magnitude and sign
   logic [tcc_pkg::MAG_W-1:0] s4_sum, s4_b;
   assign s4_sum = {1'b0, s3_at_ff[63:16]} + {19'b0, s3_tot_ff, 16'b0};
   assign s4_b   = {17'b0, s3_b_ff};

   logic s4_vld_ff, s4_neg_ff;
   tcc_pkg::kind_type s4_kind_ff;
   logic [13:0] s4_tot_ff;
   logic [tcc_pkg::MAG_W-1:0] s4_mag_ff;
   logic [63:0] s4_ac_ff;
   logic [tcc_pkg::DEN_W-1:0] s4_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_kind_ff <= s3_kind_ff;
         s4_tot_ff  <= s3_tot_ff;
         s4_neg_ff  <= s4_sum < s4_b;
         s4_mag_ff  <= (s4_sum < s4_b) ? s4_b - s4_sum : s4_sum - s4_b;
         s4_ac_ff   <= s3_ac_ff;
         s4_den_ff  <= s3_den_ff;
      end
   end

   // stage 5: partial products of u^2, zero discriminant test
   logic s5_vld_ff, s5_neg_ff;
   tcc_pkg::kind_type s5_kind_ff;
   logic [13:0] s5_tot_ff;
   logic [tcc_pkg::MAG_W-1:0] s5_mag_ff;
   logic [63:0] s5_ac_ff;
   logic [tcc_pkg::DEN_W-1:0] s5_den_ff;
   logic [47:0] s5_hh_ff;
   logic [48:0] s5_hl_ff;
   logic [49:0] s5_ll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (advance) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // no root when the discriminant is zero
         if (s4_kind_ff == tcc_pkg::KIND_SOLVE && s4_mag_ff == '0 && s4_ac_ff == '0) begin
            s5_kind_ff <= tcc_pkg::KIND_ZERO;
         end else begin
            s5_kind_ff <= s4_kind_ff;
         end
         s5_tot_ff <= s4_tot_ff;
         s5_neg_ff <= s4_neg_ff;
         s5_mag_ff <= s4_mag_ff;
         s5_ac_ff  <= s4_ac_ff;
         s5_den_ff <= s4_den_ff;
         s5_hh_ff  <= 48'(s4_mag_ff[48:25]) * 48'(s4_mag_ff[48:25]);
         s5_hl_ff  <= 49'(s4_mag_ff[48:25]) * 49'(s4_mag_ff[24:0]);
         s5_ll_ff  <= 50'(s4_mag_ff[24:0]) * 50'(s4_mag_ff[24:0]);
      end
   end

   // stage 6: discriminant u^2 + 4ac
   logic s6_vld_ff;
   logic [tcc_pkg::RAD_W-1:0] s6_rad_ff;
   tcc_pkg::sq_carry_type s6_carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (advance) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_rad_ff <= {2'b0, s5_hh_ff, 50'b0} + {25'b0, s5_hl_ff, 26'b0}
                    + {50'b0, s5_ll_ff} + {34'b0, s5_ac_ff, 2'b0};
         s6_carry_ff <= '{kind: s5_kind_ff, tot: s5_tot_ff, mag: s5_mag_ff,
                          neg: s5_neg_ff, den: s5_den_ff};
      end
   end

   logic sq_vld;
   logic [tcc_pkg::ROOT_W-1:0] sq_root;
   tcc_pkg::sq_carry_type sq_carry;

   tcc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s6_vld_ff),
      .in_rad    (s6_rad_ff),
      .in_carry  (s6_carry_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_carry (sq_carry)
   );

   // numerator u + sqrt(D), saturate when the quotient would not fit
   logic [tcc_pkg::DEN_W-1:0] num;
   assign num = sq_carry.neg ? tcc_pkg::DEN_W'(sq_root) - tcc_pkg::DEN_W'(sq_carry.mag)
                             : tcc_pkg::DEN_W'(sq_root) + tcc_pkg::DEN_W'(sq_carry.mag);

   logic n_vld_ff;
   logic [tcc_pkg::DEN_W-1:0] n_num_ff, n_den_ff;
   tcc_pkg::div_carry_type n_carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
      end else if (advance) begin
         n_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_num_ff         <= num;
         n_den_ff         <= sq_carry.den;
         n_carry_ff.tot   <= sq_carry.tot;
         n_carry_ff.kind  <= (sq_carry.kind == tcc_pkg::KIND_SOLVE && num >= sq_carry.den)
                             ? tcc_pkg::KIND_SAT : sq_carry.kind;
      end
   end

   logic dv_vld;
   logic [tcc_pkg::Q_W-1:0] dv_quot;
   tcc_pkg::div_carry_type dv_carry;

   tcc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (n_vld_ff),
      .in_num    (n_num_ff),
      .in_den    (n_den_ff),
      .in_carry  (n_carry_ff),
      .out_valid (dv_vld),
      .out_quot  (dv_quot),
      .out_carry (dv_carry)
   );

   // output register
   logic [31:0] charge_in, charge_ff;
   logic        ok_in, ok_ff;

   always_comb begin
      unique case (dv_carry.kind)
         tcc_pkg::KIND_PASS: begin
            charge_in = {2'b0, dv_carry.tot, 16'b0};
            ok_in     = 1'b1;
         end
         tcc_pkg::KIND_ZERO: begin
            charge_in = '0;
            ok_in     = 1'b0;
         end
         tcc_pkg::KIND_SAT: begin
            charge_in = '1;
            ok_in     = 1'b1;
         end
         default: begin
            charge_in = dv_quot;
            ok_in     = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         charge_ff <= charge_in;
         ok_ff     <= ok_in;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.charge_out = charge_ff;
   assign rsp_port.root_ok    = ok_ff;

   `TCC_ASSERT(a_fail_is_zero, (rsp_port.valid && !rsp_port.root_ok |-> rsp_port.charge_out == '0), "failed root with nonzero charge")
   `TCC_ASSERT(a_ready_only_on_stall, (!req_port.ready |-> rsp_port.valid && !rsp_port.ready), "request stalled without output stall")
   `TCC_ASSERT(a_empty_after_reset, ($past(reset) |-> !rsp_port.valid), "result shown right after reset")
endmodule

// ===== dv/tot_to_charge_calibration_tb.sv =====
// Testbench for the ToT to charge calibration block: directed and random items, self-checking.
`timescale 1ns / 100ps
module tot_to_charge_calibration_tb;

   localparam logic [63:0] TWO_K_SCALE = 64'd492132;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic [31:0] charge;
      logic        ok;
   } charge_type;

   typedef struct packed {
      logic [31:0] gain;
      logic [31:0] offset;
      logic [31:0] curve;
      logic [31:0] threshold;
   } curve_params_type;

   typedef struct packed {
      logic             func;
      logic [7:0]       row;
      logic [7:0]       col;
      logic [13:0]      tot;
      curve_params_type load;
   } hit_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   tcc_req_if req_if();
   tcc_rsp_if rsp_if();

   tot_to_charge_calibration u_top (
      .clock(clock), .reset(reset), .req_port(req_if), .rsp_port(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tcc_pkg::method_type cur_method;
   curve_params_type    avg_params;
   curve_params_type    pixel_params[int];
   int                  loaded_pixels[$];
   charge_type          charge_q[$];
   bit                  calm = 1'b0;
   int                  fail_count = 0;
   int                  checked_count = 0;
   int                  hit_count = 0;
   int                  load_count = 0;
   int                  sat_count = 0;
   int                  noroot_count = 0;
   int                  cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Charge from the larger root of the surrogate curve, Q16.16.
   function automatic charge_type solve_charge(logic [13:0] tot, curve_params_type p);
      logic [63:0]  prod, sum, mag, root, cand, n, den;
      logic [127:0] disc, quo;
      logic         neg;
      charge_type   r;
      r = '0;
      if (p.gain == 0) return r;
      prod = ({32'b0, p.gain} * {32'b0, p.threshold}) >> 16;
      sum = prod + ({50'b0, tot} << 16);
      if (sum >= {32'b0, p.offset}) begin
         neg = 1'b0;
         mag = sum - {32'b0, p.offset};
      end else begin
         neg = 1'b1;
         mag = {32'b0, p.offset} - sum;
      end
      disc = {64'b0, mag} * {64'b0, mag} + (({96'b0, p.gain} * {96'b0, p.curve}) << 2);
      if (disc == 0) return r;
      root = '0;
      for (int k = 52; k >= 0; k--) begin
         cand = root | (64'd1 << k);
         if ({64'b0, cand} * {64'b0, cand} <= disc) root = cand;
      end
      n = neg ? root - mag : root + mag;
      den = {32'b0, p.gain} * TWO_K_SCALE;
      r.ok = 1'b1;
      if (n >= den) r.charge = '1;
      else begin
         quo = ({64'b0, n} << 32) / {64'b0, den};
         r.charge = quo[31:0];
      end
      return r;
   endfunction

   // Update tables or queue the expected charge for an accepted item.
   task automatic record_item(hit_item_type it);
      charge_type exp_c;
      int idx;
      idx = it.row * 256 + it.col;
      if (it.func) begin
         if (!pixel_params.exists(idx)) loaded_pixels.push_back(idx);
         pixel_params[idx] = it.load;
         load_count++;
      end else begin
         case (cur_method)
            tcc_pkg::METHOD_AVG:   exp_c = solve_charge(it.tot, avg_params);
            tcc_pkg::METHOD_PIXEL: exp_c = solve_charge(it.tot, pixel_params[idx]);
            default:               exp_c = '{charge: {2'b0, it.tot, 16'b0}, ok: 1'b1};
         endcase
         if (exp_c.charge == '1) sat_count++;
         if (!exp_c.ok) noroot_count++;
         charge_q.push_back(exp_c);
         hit_count++;
      end
   endtask

   task automatic send_item(hit_item_type it);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 21) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func <= it.func;
      req_if.row <= it.row;
      req_if.col <= it.col;
      req_if.tot <= it.tot;
      req_if.load_gain <= it.load.gain;
      req_if.load_offset <= it.load.offset;
      req_if.load_curve <= it.load.curve;
      req_if.load_threshold <= it.load.threshold;
      do @(posedge clock); while (!req_if.ready);
      record_item(it);
   endtask

   task automatic send_hit(logic [13:0] tot, logic [7:0] row = '0, logic [7:0] col = '0);
      send_item('{func: 1'b0, row: row, col: col, tot: tot, load: '0});
   endtask

   task automatic send_load(logic [7:0] row, logic [7:0] col, curve_params_type p);
      send_item('{func: 1'b1, row: row, col: col, tot: 14'($urandom_range(16383)), load: p});
   endtask

   // Hold off until every expected charge is back and the pipeline is empty.
   task automatic drain;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (charge_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(tcc_pkg::csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         tcc_pkg::CSR_METHOD:    cur_method = tcc_pkg::method_type'(data[1:0]);
         tcc_pkg::CSR_GAIN:      avg_params.gain = data;
         tcc_pkg::CSR_OFFSET:    avg_params.offset = data;
         tcc_pkg::CSR_CURVE:     avg_params.curve = data;
         tcc_pkg::CSR_THRESHOLD: avg_params.threshold = data;
         default: ;
      endcase
   endtask

   task automatic write_avg(curve_params_type p);
      write_csr(tcc_pkg::CSR_GAIN, p.gain);
      write_csr(tcc_pkg::CSR_OFFSET, p.offset);
      write_csr(tcc_pkg::CSR_CURVE, p.curve);
      write_csr(tcc_pkg::CSR_THRESHOLD, p.threshold);
   endtask

   function automatic logic [31:0] rand_param();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(255);
         2: return $urandom_range(1, 1 << 26);
         default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
   endfunction

   function automatic curve_params_type rand_curve();
      return '{gain: rand_param(), offset: rand_param(), curve: rand_param(),
               threshold: rand_param()};
   endfunction

   function automatic logic [13:0] rand_tot();
      case ($urandom_range(5))
         0: return 14'd0;
         1: return 14'h3FFF;
         default: return 14'($urandom_range(16383));
      endcase
   endfunction

   always @(negedge clock) rsp_if.ready <= calm || ($urandom_range(99) >= 21);

   always @(posedge clock) begin
      charge_type exp_c;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         checked_count++;
         if (charge_q.size() == 0) begin
            $error("unexpected charge item: charge_out %h root_ok %b",
                   rsp_if.charge_out, rsp_if.root_ok);
            fail_count++;
         end else begin
            exp_c = charge_q.pop_front();
            if (rsp_if.charge_out !== exp_c.charge) begin
               $error("charge_out: expected %h actual %h", exp_c.charge, rsp_if.charge_out);
               fail_count++;
            end
            if (rsp_if.root_ok !== exp_c.ok) begin
               $error("root_ok: expected %b actual %b", exp_c.ok, rsp_if.root_ok);
               fail_count++;
            end
         end
      end
   end

   task automatic test_pass_through;
      write_csr(tcc_pkg::CSR_METHOD, tcc_pkg::METHOD_PASS);
      send_hit(14'd0);
      send_hit(14'h3FFF);
      send_hit(14'h2AAA, 8'hFF, 8'hFF);
      drain();
      // reserved method code behaves as pass through
      write_csr(tcc_pkg::CSR_METHOD, tcc_pkg::METHOD_RSVD);
      send_hit(14'h1555);
      send_hit(14'h3FFF);
      drain();
   endtask

   task automatic test_averaged;
      write_csr(tcc_pkg::CSR_METHOD, tcc_pkg::METHOD_AVG);
      send_hit(14'd0);
      send_hit(14'd100);
      send_hit(14'h3FFF);
      drain();
      // zero gain gives no root
      write_csr(tcc_pkg::CSR_GAIN, 32'h0);
      send_hit(14'd50);
      drain();
      // zero discriminant: unit gain, t and c zero, offset equals ToT
      write_avg('{gain: 32'h0001_0000, offset: 32'd77 << 16, curve: 32'h0, threshold: 32'h0});
      send_hit(14'd77);
      send_hit(14'd78);
      drain();
      // tiny gain with large curve drives saturation
      write_avg('{gain: 32'h1, offset: 32'h0, curve: 32'hFFFF_FFFF, threshold: 32'h0});
      send_hit(14'd10);
      drain();
      write_avg('{gain: '1, offset: '1, curve: '1, threshold: '1});
      send_hit(14'd0);
      send_hit(14'h3FFF);
      drain();
   endtask

   task automatic test_pixel_tables;
      write_csr(tcc_pkg::CSR_METHOD, tcc_pkg::METHOD_PIXEL);
      send_load(8'd0, 8'd0, '{gain: 32'd12188, offset: 32'd1872213, curve: 32'd1174286,
                              threshold: 32'd21372226});
      send_load(8'hFF, 8'hFF, '{gain: '1, offset: '1, curve: '1, threshold: '1});
      send_load(8'h12, 8'h34, '0);
      send_hit(14'd20, 8'd0, 8'd0);
      send_hit(14'h3FFF, 8'hFF, 8'hFF);
      send_hit(14'd5, 8'h12, 8'h34);
      // reload a pixel and hit it straight after
      send_load(8'd0, 8'd0, '{gain: 32'h0001_0000, offset: 32'h0, curve: 32'h0, threshold: 32'h0});
      send_hit(14'd0, 8'd0, 8'd0);
      send_hit(14'd9, 8'd0, 8'd0);
      drain();
   endtask

   task automatic test_random;
      hit_item_type it;
      int idx;
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         calm = (phase == 4);
         write_csr(tcc_pkg::CSR_METHOD,
                   (phase < 2) ? 32'(tcc_pkg::METHOD_AVG) : 32'($urandom_range(3)));
         case (phase)
            0: write_avg('{gain: '1, offset: '1, curve: '1, threshold: '1});
            1: write_avg('{gain: '0, offset: '0, curve: '0, threshold: '0});
            2: write_avg('{gain: 32'd12188, offset: 32'd1872213, curve: 32'd1174286,
                           threshold: 32'd21372226});
            default: write_avg(rand_curve());
         endcase
         for (int n = 0; n < 200; n++) begin
            if (phase == 3 && n == 100) drain();
            it.func = ($urandom_range(99) < 20) ||
                      (cur_method == tcc_pkg::METHOD_PIXEL && loaded_pixels.size() == 0);
            it.tot = rand_tot();
            it.load = rand_curve();
            if (it.func) begin
               // keep most loads on a small pool so pixels get reused
               it.row = 8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3));
               it.col = 8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3));
            end else if (cur_method == tcc_pkg::METHOD_PIXEL) begin
               idx = loaded_pixels[$urandom_range(loaded_pixels.size() - 1)];
               it.row = 8'(idx / 256);
               it.col = 8'(idx % 256);
            end else begin
               it.row = 8'($urandom);
               it.col = 8'($urandom);
            end
            send_item(it);
         end
      end
      calm = 1'b0;
      drain();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.func = 1'b0;
      req_if.row = '0;
      req_if.col = '0;
      req_if.tot = '0;
      req_if.load_gain = '0;
      req_if.load_offset = '0;
      req_if.load_curve = '0;
      req_if.load_threshold = '0;
      rsp_if.ready = 1'b0;
      cur_method = tcc_pkg::METHOD_PASS;
      avg_params = '{gain: 32'd12188, offset: 32'd1872213, curve: 32'd1174286,
                     threshold: 32'd21372226};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_pass_through();
      test_averaged();
      test_pixel_tables();
      test_random();
      $display("Covered %0d conversions and %0d table loads over pass, averaged and pixel modes.",
               hit_count, load_count);
      $display("Checked %0d results: %0d saturated, %0d with no root, %0d mismatches.",
               checked_count, sat_count, noroot_count, fail_count);
      if (fail_count == 0 && charge_q.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
